@@ rtl/ppat_pkg.sv @@
// Shared types and constants for the pulse packet arrival timer.
package ppat_pkg;

   // Fixed field widths
   localparam int TIME_W = 32;
   localparam int CHAN_W = 2;
   localparam int MASK_W = 4;
   localparam int SUM_W  = 39;

   // Defaults for the top-level parameters
   localparam int PULSES_DEF   = 24;
   localparam int CHANNELS_DEF = 4;

   // Blanking register reset and valid-center limit
   localparam logic [TIME_W-1:0] BLANK_RESET  = 32'd180000;
   localparam logic [TIME_W-1:0] CENTER_LIMIT = 32'h0FFF_FFFF;

   // Divider: quotient bits resolved per pipeline stage
   localparam int DIV_BITS   = 4;
   localparam int DIV_STAGES = TIME_W / DIV_BITS;

   // Depth of the queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // Operation codes
   localparam logic OP_EDGE  = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   // Classified word handed from front to back
   typedef struct packed {
      logic              clear;
      logic              edge_ok;
      logic [CHAN_W-1:0] channel;
      logic [TIME_W-1:0] capture_time;
   } cmd_type;

   // Per-word control carried alongside the divider
   typedef struct packed {
      logic              clear;
      logic              accepted;
      logic              done;
      logic              edge_ok;
      logic [CHAN_W-1:0] channel;
      logic [MASK_W-1:0] ready_mask;
   } tag_type;

endpackage

@@ rtl/ppat_intf.sv @@
// Valid/ready channel interfaces for edge requests and results.
interface ppat_req_if;
   logic                         valid;
   logic                         ready;
   logic                         op;
   logic [ppat_pkg::CHAN_W-1:0]  channel;
   logic [ppat_pkg::TIME_W-1:0]  capture_time;

   modport source (output valid, op, channel, capture_time, input ready);
   modport sink   (input valid, op, channel, capture_time, output ready);
endinterface

interface ppat_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         accepted;
   logic                         packet_done;
   logic [ppat_pkg::TIME_W-1:0]  packet_center;
   logic [ppat_pkg::MASK_W-1:0]  ready_mask;
   logic [ppat_pkg::CHAN_W-1:0]  earliest_channel;
   logic                         earliest_valid;

   modport source (output valid, accepted, packet_done, packet_center, ready_mask,
                   earliest_channel, earliest_valid, input ready);
   modport sink   (input valid, accepted, packet_done, packet_center, ready_mask,
                   earliest_channel, earliest_valid, output ready);
endinterface

@@ rtl/ppat_front.sv @@
// Front end: takes request words and classifies them for the back end.
module ppat_front #(
   parameter int CHANNELS = ppat_pkg::CHANNELS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   ppat_req_if.sink          req,
   output logic              push_valid,
   output ppat_pkg::cmd_type push_cmd,
   input  logic              push_ready
);
   import ppat_pkg::*;

   logic    valid_ff, valid_in;
   cmd_type cmd_ff, cmd_in;
   logic    take;

   // One-word holding stage; refills in the cycle it drains
   assign req.ready = !valid_ff || push_ready;
   assign take      = req.valid && req.ready;

   // Classify: clear, or an edge on an existing channel
   always_comb begin
      cmd_in              = cmd_ff;
      cmd_in.clear        = (req.op == OP_CLEAR);
      cmd_in.edge_ok      = (req.op == OP_EDGE) &&
                            ({{(TIME_W-CHAN_W){1'b0}}, req.channel} < TIME_W'(CHANNELS));
      cmd_in.channel      = req.channel;
      cmd_in.capture_time = req.capture_time;
   end

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (push_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         cmd_ff <= cmd_in;
      end
   end

   assign push_valid = valid_ff;
   assign push_cmd   = cmd_ff;

endmodule

@@ rtl/ppat_queue.sv @@
// Short FIFO that decouples the front end from the back end.
module ppat_queue #(
   parameter int DEPTH = ppat_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  ppat_pkg::cmd_type push_cmd,
   output logic              push_ready,
   output logic              pop_valid,
   output ppat_pkg::cmd_type pop_cmd,
   input  logic              pop_ready
);
   import ppat_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            store_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push, pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_cmd    = store_ff[rd_ptr_ff];

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ rtl/ppat_div.sv @@
// Pipelined restoring divider: edge sum over the edge count, 4 quotient bits per stage.
module ppat_div #(
   parameter int EDGES = 2 * ppat_pkg::PULSES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        enable,
   input  logic                        in_valid,
   input  logic [ppat_pkg::SUM_W-1:0]  in_sum,
   input  ppat_pkg::tag_type           in_tag,
   output logic                        out_valid,
   output logic [ppat_pkg::TIME_W-1:0] out_quot,
   output ppat_pkg::tag_type           out_tag
);
   import ppat_pkg::*;

   localparam int REM_W = $clog2(EDGES + 1);

   // Partial remainder stays below EDGES; the low word shifts quotient bits in
   logic              valid_ff [DIV_STAGES];
   tag_type           tag_ff   [DIV_STAGES];
   logic [REM_W-1:0]  rem_ff   [DIV_STAGES];
   logic [REM_W-1:0]  rem_in   [DIV_STAGES];
   logic [TIME_W-1:0] work_ff  [DIV_STAGES];
   logic [TIME_W-1:0] work_in  [DIV_STAGES];
   logic              src_valid [DIV_STAGES];
   tag_type           src_tag   [DIV_STAGES];
   logic [REM_W-1:0]  src_rem   [DIV_STAGES];
   logic [TIME_W-1:0] src_work  [DIV_STAGES];

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      // Stage input: the sum's top bits start the remainder (sum < EDGES * 2^32)
      if (s == 0) begin : g_first
         assign src_valid[s] = in_valid;
         assign src_tag[s]   = in_tag;
         assign src_rem[s]   = REM_W'(in_sum >> TIME_W);
         assign src_work[s]  = in_sum[TIME_W-1:0];
      end else begin : g_next
         assign src_valid[s] = valid_ff[s-1];
         assign src_tag[s]   = tag_ff[s-1];
         assign src_rem[s]   = rem_ff[s-1];
         assign src_work[s]  = work_ff[s-1];
      end

      // Shift-subtract steps of this stage
      always_comb begin
         logic [REM_W:0]    trial;
         logic [REM_W-1:0]  rem;
         logic [TIME_W-1:0] work;
         rem  = src_rem[s];
         work = src_work[s];
         for (int b = 0; b < DIV_BITS; b++) begin
            trial = {rem, work[TIME_W-1]};
            if (trial >= (REM_W+1)'(EDGES)) begin
               rem  = REM_W'(trial - (REM_W+1)'(EDGES));
               work = {work[TIME_W-2:0], 1'b1};
            end else begin
               rem  = trial[REM_W-1:0];
               work = {work[TIME_W-2:0], 1'b0};
            end
         end
         rem_in[s]  = rem;
         work_in[s] = work;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (enable) begin
            valid_ff[s] <= src_valid[s];
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            tag_ff[s]  <= src_tag[s];
            rem_ff[s]  <= rem_in[s];
            work_ff[s] <= work_in[s];
         end
      end
   end

   assign out_valid = valid_ff[DIV_STAGES-1];
   assign out_tag   = tag_ff[DIV_STAGES-1];
   assign out_quot  = work_ff[DIV_STAGES-1];

endmodule

@@ rtl/ppat_back.sv @@
// Back end: per-channel packet state, center divide, earliest tracking and result register.
module ppat_back #(
   parameter int PULSES   = ppat_pkg::PULSES_DEF,
   parameter int CHANNELS = ppat_pkg::CHANNELS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        pop_valid,
   input  ppat_pkg::cmd_type           pop_cmd,
   output logic                        pop_ready,
   input  logic [ppat_pkg::TIME_W-1:0] blank_ticks,
   ppat_rsp_if.source                  rsp
);
   import ppat_pkg::*;

   localparam int EDGES = 2 * PULSES;
   localparam int CNT_W = $clog2(EDGES + 1);
   localparam int CH_W  = $clog2(CHANNELS);
   localparam int CLR_W = $clog2(DIV_STAGES + 2);

   // Per-channel state
   logic [CNT_W-1:0]  count_ff  [CHANNELS];
   logic [CNT_W-1:0]  count_in  [CHANNELS];
   logic [SUM_W-1:0]  sum_ff    [CHANNELS];
   logic [SUM_W-1:0]  sum_in    [CHANNELS];
   logic [TIME_W-1:0] center_ff [CHANNELS];
   logic [TIME_W-1:0] center_in [CHANNELS];
   logic [TIME_W-1:0] blank_ff  [CHANNELS];
   logic [TIME_W-1:0] blank_in  [CHANNELS];

   // Earliest-center tracking
   logic              best_valid_ff, best_valid_in;
   logic [CH_W-1:0]   best_ch_ff, best_ch_in;
   logic [TIME_W-1:0] best_val_ff, best_val_in;

   // Clears between the update stage and the result register
   logic [CLR_W-1:0]  clr_cnt_ff, clr_cnt_in;

   // Update stage
   logic              b1_valid_ff;
   tag_type           b1_tag_ff, b1_tag_in;
   logic [SUM_W-1:0]  b1_sum_ff;

   // Divider output
   logic              dv;
   logic [TIME_W-1:0] dq;
   tag_type           dtag;

   // Result register
   logic              rsp_valid_ff;
   logic              rsp_acc_ff, rsp_done_ff, rsp_evalid_ff;
   logic [TIME_W-1:0] rsp_center_ff, rsp_center_in;
   logic [MASK_W-1:0] rsp_mask_ff;
   logic [CHAN_W-1:0] rsp_ech_ff;

   logic              adv, pop, pop_clear, take, done, fin;
   logic [CH_W-1:0]   idx, fidx;
   logic [CNT_W-1:0]  cnt_next;
   logic [SUM_W-1:0]  sum_next;
   logic [MASK_W-1:0] full_mask;
   logic              new_best;

   // The whole back pipeline moves when the result register can take a word
   assign adv       = !rsp_valid_ff || rsp.ready;
   assign pop_ready = adv;
   assign pop       = pop_valid && adv;
   assign pop_clear = pop && pop_cmd.clear;

   // Edge check: packet incomplete and time past the blanking end
   assign idx      = CH_W'(pop_cmd.channel);
   assign cnt_next = count_ff[idx] + 1'b1;
   assign sum_next = sum_ff[idx] + SUM_W'(pop_cmd.capture_time);
   assign take     = pop && pop_cmd.edge_ok && (count_ff[idx] < CNT_W'(EDGES)) &&
                     (pop_cmd.capture_time > blank_ff[idx]);
   assign done     = take && (cnt_next == CNT_W'(EDGES));

   // Ready bits after this word
   for (genvar i = 0; i < MASK_W; i++) begin : g_mask
      if (i < CHANNELS) begin : g_live
         assign full_mask[i] = (count_ff[i] == CNT_W'(EDGES)) || (done && idx == CH_W'(i));
      end else begin : g_none
         assign full_mask[i] = 1'b0;
      end
   end

   always_comb begin
      b1_tag_in            = b1_tag_ff;
      b1_tag_in.clear      = pop_cmd.clear;
      b1_tag_in.accepted   = take;
      b1_tag_in.done       = done;
      b1_tag_in.edge_ok    = pop_cmd.edge_ok;
      b1_tag_in.channel    = pop_cmd.channel;
      b1_tag_in.ready_mask = pop_cmd.clear ? '0 : full_mask;
   end

   // Count and sum update, one channel a word; a clear zeroes every channel
   always_comb begin
      count_in = count_ff;
      sum_in   = sum_ff;
      if (pop_clear) begin
         for (int c = 0; c < CHANNELS; c++) begin
            count_in[c] = '0;
            sum_in[c]   = '0;
         end
      end else if (take) begin
         count_in[idx] = cnt_next;
         sum_in[idx]   = sum_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            count_ff[c] <= '0;
            sum_ff[c]   <= '0;
         end
         b1_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         sum_ff   <= sum_in;
         if (adv) begin
            b1_valid_ff <= pop;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b1_tag_ff <= b1_tag_in;
         b1_sum_ff <= sum_next;
      end
   end

   ppat_div #(
      .EDGES (EDGES)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .enable    (adv),
      .in_valid  (b1_valid_ff),
      .in_sum    (b1_sum_ff),
      .in_tag    (b1_tag_ff),
      .out_valid (dv),
      .out_quot  (dq),
      .out_tag   (dtag)
   );

   assign fin  = adv && dv;
   assign fidx = CH_W'(dtag.channel);

   // Clears in flight; a completion ahead of one must not leave a blanking end
   always_comb begin
      clr_cnt_in = clr_cnt_ff;
      if (pop_clear && !(fin && dtag.clear)) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
      end else if (!pop_clear && fin && dtag.clear) begin
         clr_cnt_in = clr_cnt_ff - 1'b1;
      end
   end

   // Blanking ends: zeroed on a taken clear, set when a packet lands and no clear is in flight
   always_comb begin
      blank_in = blank_ff;
      if (pop_clear) begin
         for (int c = 0; c < CHANNELS; c++) begin
            blank_in[c] = '0;
         end
      end else if (fin && dtag.done && clr_cnt_ff == '0) begin
         blank_in[fidx] = dq + blank_ticks;
      end
   end

   // Centers and the earliest one
   assign new_best = (dq != '0) && (dq < CENTER_LIMIT) &&
                     (!best_valid_ff || dq < best_val_ff ||
                      (dq == best_val_ff && fidx < best_ch_ff));

   always_comb begin
      center_in     = center_ff;
      best_valid_in = best_valid_ff;
      best_ch_in    = best_ch_ff;
      best_val_in   = best_val_ff;
      if (fin && dtag.clear) begin
         for (int c = 0; c < CHANNELS; c++) begin
            center_in[c] = '0;
         end
         best_valid_in = 1'b0;
         best_ch_in    = '0;
         best_val_in   = '0;
      end else if (fin && dtag.done) begin
         center_in[fidx] = dq;
         if (new_best) begin
            best_valid_in = 1'b1;
            best_ch_in    = fidx;
            best_val_in   = dq;
         end
      end
   end

   assign rsp_center_in = dtag.edge_ok ? center_in[fidx] : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            center_ff[c] <= '0;
            blank_ff[c]  <= '0;
         end
         best_valid_ff <= 1'b0;
         best_ch_ff    <= '0;
         best_val_ff   <= '0;
         clr_cnt_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         center_ff     <= center_in;
         blank_ff      <= blank_in;
         best_valid_ff <= best_valid_in;
         best_ch_ff    <= best_ch_in;
         best_val_ff   <= best_val_in;
         clr_cnt_ff    <= clr_cnt_in;
         if (adv) begin
            rsp_valid_ff <= dv;
         end
      end
   end

   // Result word
   always_ff @(posedge clock) begin
      if (fin) begin
         rsp_acc_ff    <= dtag.accepted;
         rsp_done_ff   <= dtag.done;
         rsp_center_ff <= rsp_center_in;
         rsp_mask_ff   <= dtag.ready_mask;
         rsp_ech_ff    <= CHAN_W'(best_ch_in);
         rsp_evalid_ff <= best_valid_in;
      end
   end

   assign rsp.valid            = rsp_valid_ff;
   assign rsp.accepted         = rsp_acc_ff;
   assign rsp.packet_done      = rsp_done_ff;
   assign rsp.packet_center    = rsp_center_ff;
   assign rsp.ready_mask       = rsp_mask_ff;
   assign rsp.earliest_channel = rsp_ech_ff;
   assign rsp.earliest_valid   = rsp_evalid_ff;

endmodule

@@ rtl/pulse_packet_arrival_timer_top.sv @@
// Top level of the pulse packet arrival timer.
// Takes one edge or clear word per cycle and returns one result word for each,
// in order. Sustained rate is one word per cycle while the result side keeps
// up; the per-channel count/sum update is written back as the word is taken,
// so the next word sees it. A request passes the front register, the queue,
// the update stage, the center divider stages (4 quotient bits a stage) and
// the result register, in that order. The blanking register may be written
// only while no word is in flight. No clearing pass after reset.
module pulse_packet_arrival_timer_top #(
   parameter int PULSES   = ppat_pkg::PULSES_DEF,
   parameter int CHANNELS = ppat_pkg::CHANNELS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   ppat_req_if.sink                    req,
   ppat_rsp_if.source                  rsp,
   input  logic                        csr_wr_en,
   input  logic [ppat_pkg::TIME_W-1:0] csr_wr_data
);
   import ppat_pkg::*;

   logic [TIME_W-1:0] blank_ticks_ff;
   logic              push_valid, push_ready;
   cmd_type           push_cmd;
   logic              pop_valid, pop_ready;
   cmd_type           pop_cmd;

   // Blanking ticks register
   always_ff @(posedge clock) begin
      if (reset) begin
         blank_ticks_ff <= BLANK_RESET;
      end else if (csr_wr_en) begin
         blank_ticks_ff <= csr_wr_data;
      end
   end

   ppat_front #(
      .CHANNELS (CHANNELS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready)
   );

   ppat_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_cmd    (pop_cmd),
      .pop_ready  (pop_ready)
   );

   ppat_back #(
      .PULSES   (PULSES),
      .CHANNELS (CHANNELS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_valid   (pop_valid),
      .pop_cmd     (pop_cmd),
      .pop_ready   (pop_ready),
      .blank_ticks (blank_ticks_ff),
      .rsp         (rsp)
   );

endmodule
